>>> rtl/core/pevf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pevf_pkg
// Shared types and constants of the polygon extreme vertex finder.
// ----------------------------------------------------------------------------
package pevf_pkg;

	localparam int MAX_VERTICES_DEF = 4096;
	localparam int COORD_BITS_DEF   = 16;
	localparam int IDX_W            = 12;
	localparam int MIN_VERTICES     = 3;
	localparam int SLOTS            = 4;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [1:0] SLOT_MIN_X = 2'd0;
	localparam logic [1:0] SLOT_MAX_Y = 2'd1;
	localparam logic [1:0] SLOT_MAX_X = 2'd2;
	localparam logic [1:0] SLOT_MIN_Y = 2'd3;

	typedef enum logic [1:0] {
		KIND_FIRST,
		KIND_CONSIDER,
		KIND_SKIP
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_MANY = 2'd2
	} status_t;

	typedef struct packed {
		kind_t            kind;
		logic             last;
		status_t          status;
		logic [IDX_W-1:0] idx;
	} meta_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} snap_ctl_t;

endpackage

>>> rtl/core/pevf_vert_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pevf_vert_if
// Vertex channel: one beat carries one polygon vertex.
// ----------------------------------------------------------------------------
interface pevf_vert_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vert_x;
	logic signed [COORD_BITS-1:0] vert_y;
	logic                         last_vertex;

	modport source (output valid, output vert_x, output vert_y, output last_vertex,
		input ready);
	modport sink (input valid, input vert_x, input vert_y, input last_vertex,
		output ready);
endinterface

>>> rtl/core/pevf_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pevf_res_if
// Result channel: one beat carries the extreme indices of one polygon.
// ----------------------------------------------------------------------------
interface pevf_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] idx_min_x;
	logic [11:0] idx_max_y;
	logic [11:0] idx_max_x;
	logic [11:0] idx_min_y;
	logic [1:0]  status;

	modport source (output valid, output idx_min_x, output idx_max_y, output idx_max_x,
		output idx_min_y, output status, input ready);
	modport sink (input valid, input idx_min_x, input idx_max_y, input idx_max_x,
		input idx_min_y, input status, output ready);
endinterface

>>> rtl/core/polygon_extreme_vertex_finder_unit.sv
`timescale 1ns / 1ps
// Throughput: one vertex beat per cycle, also across polygon ends, while the result channel is not stalled.
// After the last vertex is accepted, its result passes through the queue, the
// recheck stage and the merge stage into the output register.
// The extreme tracker compares each vertex against the four slots combinationally.
// Reset: arst_n clears the vertex count, queue and all valid flags at once;
// the block is ready for vertices straight after reset.
// ----------------------------------------------------------------------------
// polygon_extreme_vertex_finder_unit
// Finds min-x, max-y, max-x and min-y vertex indices of a streamed polygon.
// ----------------------------------------------------------------------------
module polygon_extreme_vertex_finder_unit import pevf_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pevf_vert_if.sink  vert,
	pevf_res_if.source res
);

	localparam int DATA_W = 2 * COORD_BITS + $bits(meta_t);

	logic                         push;
	logic [DATA_W-1:0]            push_data;
	logic                         q_full;
	logic                         pop;
	logic                         q_valid;
	logic [DATA_W-1:0]            q_data;
	snap_ctl_t                    snap_ctl;
	logic                         snap_ready;
	logic [IDX_W-1:0]             snap_idx [SLOTS];
	logic signed [COORD_BITS-1:0] snap_x [SLOTS];
	logic signed [COORD_BITS-1:0] snap_y [SLOTS];
	logic signed [COORD_BITS-1:0] snap_fx;
	logic signed [COORD_BITS-1:0] snap_fy;
	logic signed [COORD_BITS-1:0] snap_lx;
	logic signed [COORD_BITS-1:0] snap_ly;

	pevf_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vert     (vert),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	pevf_queue #(
		.WIDTH(DATA_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_data   (q_data)
	);

	pevf_tracker #(
		.COORD_BITS(COORD_BITS)
	) u_tracker (
		.clk       (clk),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.snap_ctl  (snap_ctl),
		.snap_ready(snap_ready),
		.snap_idx  (snap_idx),
		.snap_x    (snap_x),
		.snap_y    (snap_y),
		.snap_fx   (snap_fx),
		.snap_fy   (snap_fy),
		.snap_lx   (snap_lx),
		.snap_ly   (snap_ly)
	);

	pevf_finish #(
		.COORD_BITS(COORD_BITS)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_ctl  (snap_ctl),
		.snap_ready(snap_ready),
		.snap_idx  (snap_idx),
		.snap_x    (snap_x),
		.snap_y    (snap_y),
		.snap_fx   (snap_fx),
		.snap_fy   (snap_fy),
		.snap_lx   (snap_lx),
		.snap_ly   (snap_ly),
		.res       (res)
	);

endmodule

>>> rtl/core/pevf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pevf_front
// Counts vertices of the current polygon and classifies each beat.
// ----------------------------------------------------------------------------
module pevf_front import pevf_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	localparam int DATA_W      = 2 * COORD_BITS + $bits(meta_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	pevf_vert_if.sink         vert,
	output logic              push,
	output logic [DATA_W-1:0] push_data,
	input  logic              q_full
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 2);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] total;
	meta_t            meta;

	assign vert.ready = !q_full;
	assign push       = vert.valid && vert.ready;

	always_comb begin
		if (count_q <= CNT_W'(MAX_VERTICES)) begin
			total = count_q + CNT_W'(1);
		end else begin
			total = count_q;
		end
		meta.idx  = IDX_W'(count_q);
		meta.last = vert.last_vertex;
		priority if (count_q == '0) begin
			meta.kind = KIND_FIRST;
		end else if (count_q < CNT_W'(MAX_VERTICES)) begin
			meta.kind = KIND_CONSIDER;
		end else begin
			meta.kind = KIND_SKIP;
		end
		priority if (total < CNT_W'(MIN_VERTICES)) begin
			meta.status = ST_FEW;
		end else if (total > CNT_W'(MAX_VERTICES)) begin
			meta.status = ST_MANY;
		end else begin
			meta.status = ST_OK;
		end
	end

	assign push_data = {vert.vert_x, vert.vert_y, meta};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (vert.last_vertex) begin
				count_q <= '0;
			end else begin
				count_q <= total;
			end
		end
	end

endmodule

>>> rtl/core/pevf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pevf_queue
// Short register FIFO between the classifying front and the tracker.
// ----------------------------------------------------------------------------
module pevf_queue import pevf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output logic [WIDTH-1:0] q_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = cnt_q == CNT_W'(DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_data  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/pevf_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pevf_tracker
// Keeps the four running extremes and hands a snapshot on the last vertex.
// ----------------------------------------------------------------------------
module pevf_tracker import pevf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int DATA_W    = 2 * COORD_BITS + $bits(meta_t)
) (
	input  logic                         clk,
	input  logic                         q_valid,
	input  logic [DATA_W-1:0]            q_data,
	output logic                         pop,
	output snap_ctl_t                    snap_ctl,
	input  logic                         snap_ready,
	output logic [IDX_W-1:0]             snap_idx [SLOTS],
	output logic signed [COORD_BITS-1:0] snap_x [SLOTS],
	output logic signed [COORD_BITS-1:0] snap_y [SLOTS],
	output logic signed [COORD_BITS-1:0] snap_fx,
	output logic signed [COORD_BITS-1:0] snap_fy,
	output logic signed [COORD_BITS-1:0] snap_lx,
	output logic signed [COORD_BITS-1:0] snap_ly
);

	meta_t                        meta;
	logic signed [COORD_BITS-1:0] x;
	logic signed [COORD_BITS-1:0] y;
	logic [IDX_W-1:0]             idx_q [SLOTS];
	logic signed [COORD_BITS-1:0] x_q [SLOTS];
	logic signed [COORD_BITS-1:0] y_q [SLOTS];
	logic signed [COORD_BITS-1:0] fx_q;
	logic signed [COORD_BITS-1:0] fy_q;
	logic [IDX_W-1:0]             nx_idx [SLOTS];
	logic signed [COORD_BITS-1:0] nx_x [SLOTS];
	logic signed [COORD_BITS-1:0] nx_y [SLOTS];
	logic                         upd [SLOTS];

	assign meta = meta_t'(q_data[$bits(meta_t)-1:0]);
	assign y    = q_data[$bits(meta_t) +: COORD_BITS];
	assign x    = q_data[$bits(meta_t) + COORD_BITS +: COORD_BITS];

	assign pop             = q_valid && (!meta.last || snap_ready);
	assign snap_ctl.valid  = q_valid && meta.last;
	assign snap_ctl.status = meta.status;

	always_comb begin
		upd[SLOT_MIN_X] = x < x_q[SLOT_MIN_X];
		upd[SLOT_MAX_X] = x > x_q[SLOT_MAX_X];
		upd[SLOT_MIN_Y] = y <= y_q[SLOT_MIN_Y];
		upd[SLOT_MAX_Y] = y >= y_q[SLOT_MAX_Y];
		snap_fx = fx_q;
		snap_fy = fy_q;
		for (int s = 0; s < SLOTS; s++) begin
			nx_idx[s] = idx_q[s];
			nx_x[s]   = x_q[s];
			nx_y[s]   = y_q[s];
		end
		unique case (meta.kind)
			KIND_FIRST: begin
				snap_fx = x;
				snap_fy = y;
				for (int s = 0; s < SLOTS; s++) begin
					nx_idx[s] = meta.idx;
					nx_x[s]   = x;
					nx_y[s]   = y;
				end
			end
			KIND_CONSIDER: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (upd[s]) begin
						nx_idx[s] = meta.idx;
						nx_x[s]   = x;
						nx_y[s]   = y;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign snap_idx = nx_idx;
	assign snap_x   = nx_x;
	assign snap_y   = nx_y;
	assign snap_lx  = x;
	assign snap_ly  = y;

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q <= nx_idx;
			x_q   <= nx_x;
			y_q   <= nx_y;
			fx_q  <= snap_fx;
			fy_q  <= snap_fy;
		end
	end

endmodule

>>> rtl/core/pevf_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pevf_finish
// Rechecks vertex 0, merges extremes that share a coordinate, holds the result.
// ----------------------------------------------------------------------------
module pevf_finish import pevf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  snap_ctl_t                    snap_ctl,
	output logic                         snap_ready,
	input  logic [IDX_W-1:0]             snap_idx [SLOTS],
	input  logic signed [COORD_BITS-1:0] snap_x [SLOTS],
	input  logic signed [COORD_BITS-1:0] snap_y [SLOTS],
	input  logic signed [COORD_BITS-1:0] snap_fx,
	input  logic signed [COORD_BITS-1:0] snap_fy,
	input  logic signed [COORD_BITS-1:0] snap_lx,
	input  logic signed [COORD_BITS-1:0] snap_ly,
	pevf_res_if.source                   res
);

	logic                         valid_s1;
	status_t                      status_s1;
	logic [IDX_W-1:0]             idx_s1 [SLOTS];
	logic signed [COORD_BITS-1:0] x_s1 [SLOTS];
	logic signed [COORD_BITS-1:0] y_s1 [SLOTS];
	logic signed [COORD_BITS-1:0] fx_s1;
	logic signed [COORD_BITS-1:0] fy_s1;
	logic signed [COORD_BITS-1:0] lx_s1;
	logic signed [COORD_BITS-1:0] ly_s1;

	logic                         valid_s2;
	status_t                      status_s2;
	logic [IDX_W-1:0]             idx_s2 [SLOTS];
	logic signed [COORD_BITS-1:0] x_s2 [SLOTS];
	logic signed [COORD_BITS-1:0] y_s2 [SLOTS];

	logic [IDX_W-1:0]             rc_idx [SLOTS];
	logic signed [COORD_BITS-1:0] rc_x [SLOTS];
	logic signed [COORD_BITS-1:0] rc_y [SLOTS];
	logic                         upd [SLOTS];
	logic                         recheck;

	logic [IDX_W-1:0]             aj_idx [SLOTS];
	logic signed [COORD_BITS-1:0] aj_x [SLOTS];
	logic signed [COORD_BITS-1:0] aj_y [SLOTS];

	logic adv_s1;
	logic adv_s2;

	assign adv_s2     = !res.valid || res.ready;
	assign adv_s1     = !valid_s2 || adv_s2;
	assign snap_ready = !valid_s1 || adv_s1;

	always_comb begin
		recheck = (status_s1 == ST_OK) && ((fx_s1 != lx_s1) || (fy_s1 != ly_s1));
		upd[SLOT_MIN_X] = fx_s1 < x_s1[SLOT_MIN_X];
		upd[SLOT_MAX_X] = fx_s1 > x_s1[SLOT_MAX_X];
		upd[SLOT_MIN_Y] = fy_s1 <= y_s1[SLOT_MIN_Y];
		upd[SLOT_MAX_Y] = fy_s1 >= y_s1[SLOT_MAX_Y];
		for (int s = 0; s < SLOTS; s++) begin
			if (recheck && upd[s]) begin
				rc_idx[s] = '0;
				rc_x[s]   = fx_s1;
				rc_y[s]   = fy_s1;
			end else begin
				rc_idx[s] = idx_s1[s];
				rc_x[s]   = x_s1[s];
				rc_y[s]   = y_s1[s];
			end
		end
	end

	always_comb begin
		aj_idx = idx_s2;
		aj_x   = x_s2;
		aj_y   = y_s2;
		if (aj_y[SLOT_MIN_X] == aj_y[SLOT_MAX_Y]) begin
			aj_idx[SLOT_MAX_Y] = aj_idx[SLOT_MIN_X];
			aj_x[SLOT_MAX_Y]   = aj_x[SLOT_MIN_X];
			aj_y[SLOT_MAX_Y]   = aj_y[SLOT_MIN_X];
		end
		if (aj_x[SLOT_MIN_Y] == aj_x[SLOT_MAX_X]) begin
			aj_idx[SLOT_MAX_X] = aj_idx[SLOT_MIN_Y];
			aj_x[SLOT_MAX_X]   = aj_x[SLOT_MIN_Y];
			aj_y[SLOT_MAX_X]   = aj_y[SLOT_MIN_Y];
		end
		if (aj_y[SLOT_MAX_X] == aj_y[SLOT_MAX_Y]) begin
			aj_idx[SLOT_MAX_Y] = aj_idx[SLOT_MAX_X];
			aj_x[SLOT_MAX_Y]   = aj_x[SLOT_MAX_X];
			aj_y[SLOT_MAX_Y]   = aj_y[SLOT_MAX_X];
		end
		if (aj_x[SLOT_MIN_Y] == aj_x[SLOT_MIN_X]) begin
			aj_idx[SLOT_MIN_X] = aj_idx[SLOT_MIN_Y];
			aj_x[SLOT_MIN_X]   = aj_x[SLOT_MIN_Y];
			aj_y[SLOT_MIN_X]   = aj_y[SLOT_MIN_Y];
		end
		if (status_s2 != ST_OK) begin
			for (int s = 0; s < SLOTS; s++) begin
				aj_idx[s] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			res.valid <= 1'b0;
		end else begin
			if (snap_ready) begin
				valid_s1 <= snap_ctl.valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s2) begin
				res.valid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_ctl.valid) begin
			status_s1 <= snap_ctl.status;
			idx_s1    <= snap_idx;
			x_s1      <= snap_x;
			y_s1      <= snap_y;
			fx_s1     <= snap_fx;
			fy_s1     <= snap_fy;
			lx_s1     <= snap_lx;
			ly_s1     <= snap_ly;
		end
		if (adv_s1 && valid_s1) begin
			status_s2 <= status_s1;
			idx_s2    <= rc_idx;
			x_s2      <= rc_x;
			y_s2      <= rc_y;
		end
		if (adv_s2 && valid_s2) begin
			res.idx_min_x <= aj_idx[SLOT_MIN_X];
			res.idx_max_y <= aj_idx[SLOT_MAX_Y];
			res.idx_max_x <= aj_idx[SLOT_MAX_X];
			res.idx_min_y <= aj_idx[SLOT_MIN_Y];
			res.status    <= status_s2;
		end
	end

endmodule

>>> sim/pevf_extreme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pevf_extreme_checker
// Watches the vertex and result channels of the extreme vertex finder. It
// tracks the four extremes of each polygon on its own and queues the
// expected result on every last vertex. Each result beat is compared field
// by field against the oldest queued result.
// ----------------------------------------------------------------------------
module pevf_extreme_checker import pevf_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pevf_vert_if vert,
	pevf_res_if  res,
	output int   errors,
	output int   pending
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [IDX_W-1:0] min_x;
		logic [IDX_W-1:0] max_y;
		logic [IDX_W-1:0] max_x;
		logic [IDX_W-1:0] min_y;
		status_t          status;
	} extremes_t;

	int unsigned      seen;
	coord_t           v0_x;
	coord_t           v0_y;
	logic [IDX_W-1:0] slot_idx [SLOTS];
	coord_t           slot_x [SLOTS];
	coord_t           slot_y [SLOTS];
	extremes_t        extremes_due[$];

	task automatic report(input string msg);
		errors++;
		if (errors <= 200) begin
			$display("pevf_extreme_checker: %s", msg);
		end
	endtask

	function automatic void claim_slot(input logic [1:0] s, input logic [IDX_W-1:0] idx,
		input coord_t x, input coord_t y);
		slot_idx[s] = idx;
		slot_x[s]   = x;
		slot_y[s]   = y;
	endfunction

	function automatic void copy_slot(input logic [1:0] dst, input logic [1:0] src);
		claim_slot(dst, slot_idx[src], slot_x[src], slot_y[src]);
	endfunction

	// x keeps the first occurrence, y takes the latest
	function automatic void weigh_vertex(input logic [IDX_W-1:0] idx, input coord_t x,
		input coord_t y);
		if (x < slot_x[SLOT_MIN_X]) claim_slot(SLOT_MIN_X, idx, x, y);
		if (x > slot_x[SLOT_MAX_X]) claim_slot(SLOT_MAX_X, idx, x, y);
		if (y <= slot_y[SLOT_MIN_Y]) claim_slot(SLOT_MIN_Y, idx, x, y);
		if (y >= slot_y[SLOT_MAX_Y]) claim_slot(SLOT_MAX_Y, idx, x, y);
	endfunction

	function automatic void predict_vertex(input coord_t x, input coord_t y, input logic last);
		int unsigned total;
		extremes_t   r;
		if (seen == 0) begin
			v0_x = x;
			v0_y = y;
			for (int s = 0; s < SLOTS; s++) begin
				claim_slot(2'(s), '0, x, y);
			end
		end else if (seen < MAX_VERTICES) begin
			weigh_vertex(IDX_W'(seen), x, y);
		end
		if (seen <= MAX_VERTICES) seen++;
		total = seen;
		if (!last) return;
		seen = 0;
		r = '0;
		if (total < MIN_VERTICES) begin
			r.status = ST_FEW;
		end else if (total > MAX_VERTICES) begin
			r.status = ST_MANY;
		end else begin
			if (v0_x != x || v0_y != y) weigh_vertex('0, v0_x, v0_y);
			if (slot_y[SLOT_MIN_X] == slot_y[SLOT_MAX_Y]) copy_slot(SLOT_MAX_Y, SLOT_MIN_X);
			if (slot_x[SLOT_MIN_Y] == slot_x[SLOT_MAX_X]) copy_slot(SLOT_MAX_X, SLOT_MIN_Y);
			if (slot_y[SLOT_MAX_X] == slot_y[SLOT_MAX_Y]) copy_slot(SLOT_MAX_Y, SLOT_MAX_X);
			if (slot_x[SLOT_MIN_Y] == slot_x[SLOT_MIN_X]) copy_slot(SLOT_MIN_X, SLOT_MIN_Y);
			r.min_x  = slot_idx[SLOT_MIN_X];
			r.max_y  = slot_idx[SLOT_MAX_Y];
			r.max_x  = slot_idx[SLOT_MAX_X];
			r.min_y  = slot_idx[SLOT_MIN_Y];
			r.status = ST_OK;
		end
		extremes_due.push_back(r);
	endfunction

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	task automatic check_result();
		extremes_t want;
		if (extremes_due.size() == 0) begin
			report($sformatf("result beat with nothing due, status %0d", res.status));
			return;
		end
		want = extremes_due.pop_front();
		check_field("idx_min_x", int'(res.idx_min_x), int'(want.min_x));
		check_field("idx_max_y", int'(res.idx_max_y), int'(want.max_y));
		check_field("idx_max_x", int'(res.idx_max_x), int'(want.max_x));
		check_field("idx_min_y", int'(res.idx_min_y), int'(want.min_y));
		check_field("status", int'(res.status), int'(want.status));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen = 0;
			v0_x = '0;
			v0_y = '0;
			for (int s = 0; s < SLOTS; s++) begin
				claim_slot(2'(s), '0, '0, '0);
			end
			extremes_due.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (vert.valid && vert.ready) begin
				predict_vertex(vert.vert_x, vert.vert_y, vert.last_vertex);
			end
			if (res.valid && res.ready) begin
				check_result();
			end
			pending = extremes_due.size();
		end
	end

endmodule

>>> sim/tb_polygon_extreme_vertex_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_extreme_vertex_finder_unit
// Streams polygons into the extreme vertex finder: a directed set of corner
// cases and three random phases with different sender and receiver stalls.
// The checker beside the block predicts and compares; this module drives
// and gives the verdict.
// ----------------------------------------------------------------------------
module tb_polygon_extreme_vertex_finder_unit import pevf_pkg::*; ();

	localparam int CB          = COORD_BITS_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 570;

	typedef logic signed [CB-1:0] coord_t;

	localparam coord_t C_MIN = {1'b1, {(CB-1){1'b0}}};
	localparam coord_t C_MAX = {1'b0, {(CB-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   quiet;
	int   sent;

	pevf_vert_if #(.COORD_BITS(CB)) vert();
	pevf_res_if res();

	polygon_extreme_vertex_finder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.vert   (vert),
		.res    (res)
	);

	pevf_extreme_checker #(.COORD_BITS(CB)) u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.vert    (vert),
		.res     (res),
		.errors  (errors),
		.pending (pending)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (vert.valid && vert.ready) || (res.valid && res.ready)) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_polygon_extreme_vertex_finder_unit: done, errors");
			$finish;
		end
	end

	task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			vert.valid <= 1'b0;
			@(negedge clk);
		end
		vert.valid       <= 1'b1;
		vert.vert_x      <= x;
		vert.vert_y      <= y;
		vert.last_vertex <= last;
		@(posedge clk);
		while (!vert.ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// hold the sender until every due result is back
	task automatic drain();
		vert.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic coord_t pick_coord(input int style, input coord_t base);
		case (style)
			0: return coord_t'($urandom);
			1: return base + coord_t'($urandom_range(6)) - coord_t'(3);
			default: begin
				case ($urandom_range(4))
					0: return C_MIN;
					1: return C_MAX;
					2: return '0;
					3: return '1;
					default: return coord_t'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic send_random_polygon();
		int     n;
		int     style;
		int     r;
		coord_t bx;
		coord_t by;
		coord_t x0;
		coord_t y0;
		coord_t x;
		coord_t y;
		logic   closed;
		r = $urandom_range(99);
		if (r < 6) n = $urandom_range(2, 1);
		else if (r < 90) n = $urandom_range(12, 3);
		else n = $urandom_range(80, 13);
		style  = $urandom_range(2);
		bx     = coord_t'($urandom);
		by     = coord_t'($urandom);
		x0     = '0;
		y0     = '0;
		closed = (n >= 3) && ($urandom_range(99) < 30);
		for (int i = 0; i < n; i++) begin
			if (closed && i == n - 1) begin
				x = x0;
				y = y0;
			end else begin
				x = pick_coord(style, bx);
				y = pick_coord(style, by);
			end
			if (i == 0) begin
				x0 = x;
				y0 = y;
			end
			send_vertex(x, y, i == n - 1);
		end
	endtask

	task automatic run_phase(input int src_pct, input int sink_pct, input int items);
		int target;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		target        = sent + items;
		while (sent < target) begin
			send_random_polygon();
			if ($urandom_range(15) == 0) drain();
		end
		drain();
	endtask

	initial begin
		vert.valid       = 1'b0;
		vert.vert_x      = '0;
		vert.vert_y      = '0;
		vert.last_vertex = 1'b0;
		arst_n           = 1'b0;
		src_idle_pct     = 16;
		sink_idle_pct    = 56;
		sent             = 0;
		quiet            = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// too few vertices
		send_vertex(coord_t'(5), coord_t'(5), 1'b1);
		send_vertex(coord_t'(-1), coord_t'(3), 1'b0);
		send_vertex(coord_t'(7), coord_t'(7), 1'b1);
		// coordinate extremes
		send_vertex(C_MIN, C_MAX, 1'b0);
		send_vertex(C_MAX, C_MIN, 1'b0);
		send_vertex(coord_t'(0), coord_t'(0), 1'b1);
		// closed square, only the min-y onto min-x merge applies
		send_vertex(coord_t'(0), coord_t'(0), 1'b0);
		send_vertex(coord_t'(10), coord_t'(0), 1'b0);
		send_vertex(coord_t'(10), coord_t'(10), 1'b0);
		send_vertex(coord_t'(0), coord_t'(10), 1'b0);
		send_vertex(coord_t'(0), coord_t'(0), 1'b1);
		// ties on both axes, open polygon
		send_vertex(coord_t'(3), coord_t'(1), 1'b0);
		send_vertex(coord_t'(-2), coord_t'(1), 1'b0);
		send_vertex(coord_t'(-2), coord_t'(1), 1'b0);
		send_vertex(coord_t'(5), coord_t'(-6), 1'b0);
		send_vertex(coord_t'(5), coord_t'(1), 1'b0);
		send_vertex(coord_t'(0), coord_t'(1), 1'b1);
		// all vertices the same, then first and last vertex the same
		send_vertex(C_MIN, C_MIN, 1'b0);
		send_vertex(C_MIN, C_MIN, 1'b0);
		send_vertex(C_MIN, C_MIN, 1'b1);
		send_vertex(C_MAX, C_MAX, 1'b0);
		send_vertex(coord_t'(-1), coord_t'(-1), 1'b0);
		send_vertex(C_MAX, C_MAX, 1'b1);
		drain();

		run_phase(16, 56, PHASE_ITEMS);
		run_phase(56, 16, PHASE_ITEMS);
		run_phase(0, 0, PHASE_ITEMS);
		repeat (10) @(negedge clk);

		if (errors == 0) begin
			$display("tb_polygon_extreme_vertex_finder_unit: done, clean");
		end else begin
			$display("tb_polygon_extreme_vertex_finder_unit: done, errors");
		end
		$finish;
	end

endmodule
